// ===== rtl/alsch_pkg.sv =====
// ----------------------------------------------------------------------------
// alsch_pkg: shared constants and types of the alarm schedule table
// Table geometry, item kind codes and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package alsch_pkg;

  // Table geometry; the table holds at most TABLE_SIZE-1 entries
  localparam int TABLE_SIZE = 16;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

  // Field widths
  localparam int KIND_W  = 3;
  localparam int MIN_W   = 11;
  localparam int IDX_W   = 4;
  localparam int ENTRY_W = MIN_W + 1;  // melody bit above the minute

  // Minutes in a day
  localparam int DAY_MINUTES = 24 * 60;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // latch the incoming item
    logic dispatch;    // first step of an item: add, clear, setup of scans and shifts
    logic scan_step;   // one step of the tick/query scan
    logic shift_step;  // one step of the shift-down after a removal
    logic out_load;    // copy the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              del_ok;       // delete index below count
    logic              has_entries;  // count nonzero
    logic              pend;         // read data of the scan/shift is valid
    logic              at_end;       // read pointer reached count
    logic              match;        // tick entry under test matches
  } stat_t;

endpackage

// ===== rtl/alsch_if.sv =====
// ----------------------------------------------------------------------------
// alsch_if: item and result channels of the alarm schedule table
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface alsch_in_if;
  logic                         valid;
  logic                         ready;
  logic [alsch_pkg::KIND_W-1:0] kind;
  logic [alsch_pkg::MIN_W-1:0]  alarm_minute;
  logic                         melody;
  logic [alsch_pkg::IDX_W-1:0]  entry_index;
  logic [alsch_pkg::MIN_W-1:0]  current_minute;

  modport source (output valid, kind, alarm_minute, melody, entry_index,
                  current_minute, input ready);
  modport sink (input valid, kind, alarm_minute, melody, entry_index,
                current_minute, output ready);
endinterface

interface alsch_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic                        fired;
  logic                        fired_melody;
  logic                        nearest_valid;
  logic [alsch_pkg::IDX_W-1:0] nearest_index;
  logic [alsch_pkg::MIN_W-1:0] minutes_until;
  logic [alsch_pkg::CNT_W-1:0] entry_count;

  modport source (output valid, accepted, fired, fired_melody, nearest_valid,
                  nearest_index, minutes_until, entry_count, input ready);
  modport sink (input valid, accepted, fired, fired_melody, nearest_valid,
                nearest_index, minutes_until, entry_count, output ready);
endinterface

// ===== rtl/alsch_ram.sv =====
// ----------------------------------------------------------------------------
// alsch_ram: generic simple dual-port RAM
// One write port, one read port with registered read data, no reset.
// ----------------------------------------------------------------------------
module alsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/alsch_ctrl.sv =====
// ----------------------------------------------------------------------------
// alsch_ctrl: sequencer of the alarm schedule table
// Walks each item through dispatch, scan, shift and result hand-off.
// ----------------------------------------------------------------------------
module alsch_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output alsch_pkg::cmd_t cmd,
  input  alsch_pkg::stat_t stat
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_SHIFT    = 3'd3;
  localparam logic [2:0] ST_FIN      = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.dispatch = 1'b1;
        case (stat.kind) inside
          alsch_pkg::KIND_DELETE: state_next = stat.del_ok ? ST_SHIFT : ST_FIN;
          alsch_pkg::KIND_TICK,
          alsch_pkg::KIND_QUERY: state_next = stat.has_entries ? ST_SCAN : ST_FIN;
          default: state_next = ST_FIN;
        endcase
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.match) begin
          state_next = ST_SHIFT;
        end else if (stat.pend && stat.at_end) begin
          state_next = ST_FIN;
        end
      end
      ST_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (!stat.pend && stat.at_end) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/alsch_dpath.sv =====
// ----------------------------------------------------------------------------
// alsch_dpath: entry store, scan pointer and result registers
// Holds the entry RAM and count, evaluates tick matches and query distances
// one entry per cycle, and moves later entries down after a removal.
// ----------------------------------------------------------------------------
module alsch_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  alsch_pkg::cmd_t              cmd,
  output alsch_pkg::stat_t             stat,
  input  logic [alsch_pkg::KIND_W-1:0] kind,
  input  logic [alsch_pkg::MIN_W-1:0]  alarm_minute,
  input  logic                         melody,
  input  logic [alsch_pkg::IDX_W-1:0]  entry_index,
  input  logic [alsch_pkg::MIN_W-1:0]  current_minute,
  output logic                         accepted,
  output logic                         fired,
  output logic                         fired_melody,
  output logic                         nearest_valid,
  output logic [alsch_pkg::IDX_W-1:0]  nearest_index,
  output logic [alsch_pkg::MIN_W-1:0]  minutes_until,
  output logic [alsch_pkg::CNT_W-1:0]  entry_count
);

  localparam int DW = alsch_pkg::MIN_W + 2;  // signed distance width

  // Latched item
  logic [alsch_pkg::KIND_W-1:0] kind_q;
  logic [alsch_pkg::MIN_W-1:0]  amin_q;
  logic                         mel_q;
  logic [alsch_pkg::IDX_W-1:0]  idx_q;
  logic [alsch_pkg::MIN_W-1:0]  cur_q;

  // Table control
  logic [alsch_pkg::CNT_W-1:0]  count;
  logic [alsch_pkg::CNT_W-1:0]  ptr;
  logic [alsch_pkg::ADDR_W-1:0] pidx;
  logic                         pend;

  // Working result
  logic                         r_acc;
  logic                         r_fired;
  logic                         r_fmel;
  logic                         r_nvalid;
  logic [alsch_pkg::IDX_W-1:0]  r_nidx;
  logic [alsch_pkg::MIN_W-1:0]  r_best;

  // RAM ports
  logic                          we;
  logic [alsch_pkg::ADDR_W-1:0]  waddr;
  logic [alsch_pkg::ENTRY_W-1:0] wdata;
  logic [alsch_pkg::ENTRY_W-1:0] rdata;
  logic [alsch_pkg::MIN_W-1:0]   rd_min;
  logic                          rd_mel;

  logic add_ok;
  logic del_ok;
  logic at_end;
  logic match;
  logic signed [DW-1:0] d1;
  logic signed [DW-1:0] d2;
  logic signed [DW-1:0] d3;
  logic [alsch_pkg::MIN_W-1:0] fwd_dist;

  alsch_ram #(
    .WIDTH(alsch_pkg::ENTRY_W),
    .DEPTH(alsch_pkg::TABLE_SIZE)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(ptr[alsch_pkg::ADDR_W-1:0]),
    .rdata(rdata)
  );

  assign rd_min = rdata[alsch_pkg::MIN_W-1:0];
  assign rd_mel = rdata[alsch_pkg::MIN_W];

  // Item checks
  assign add_ok = count < alsch_pkg::CNT_W'(alsch_pkg::TABLE_SIZE - 1);
  assign del_ok = alsch_pkg::CNT_W'(idx_q) < count;
  assign at_end = ptr >= count;
  assign match  = pend && (kind_q == alsch_pkg::KIND_TICK) && (rd_min == cur_q);

  assign stat.kind        = kind_q;
  assign stat.del_ok      = del_ok;
  assign stat.has_entries = (count != '0);
  assign stat.pend        = pend;
  assign stat.at_end      = at_end;
  assign stat.match       = match;

  // Forward distance, wrapped into 1..day (or beyond for out-of-day minutes)
  always_comb begin
    d1 = $signed({2'b00, rd_min}) - $signed({2'b00, cur_q});
    d2 = d1 + $signed(DW'(alsch_pkg::DAY_MINUTES));
    d3 = d1 + $signed(DW'(2 * alsch_pkg::DAY_MINUTES));
    if (d1 > $signed(DW'(0))) begin
      fwd_dist = d1[alsch_pkg::MIN_W-1:0];
    end else if (d2 > $signed(DW'(0))) begin
      fwd_dist = d2[alsch_pkg::MIN_W-1:0];
    end else begin
      fwd_dist = d3[alsch_pkg::MIN_W-1:0];
    end
  end

  // RAM write: append on add, move down during a shift
  always_comb begin
    we    = 1'b0;
    waddr = pidx - alsch_pkg::ADDR_W'(1);
    wdata = rdata;
    if (cmd.dispatch && (kind_q == alsch_pkg::KIND_ADD) && add_ok) begin
      we    = 1'b1;
      waddr = count[alsch_pkg::ADDR_W-1:0];
      wdata = {mel_q, amin_q};
    end else if (cmd.shift_step && pend) begin
      we = 1'b1;
    end
  end

  // Item latch (payload)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      amin_q <= alarm_minute;
      mel_q  <= melody;
      idx_q  <= entry_index;
      cur_q  <= current_minute;
    end
  end

  // Count, scan pointer and working result
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
      pidx  <= '0;
      pend  <= 1'b0;
    end else if (cmd.dispatch) begin
      pend <= 1'b0;
      ptr  <= (kind_q == alsch_pkg::KIND_DELETE) ?
              alsch_pkg::CNT_W'(idx_q) + alsch_pkg::CNT_W'(1) : '0;
      if ((kind_q == alsch_pkg::KIND_ADD) && add_ok) begin
        count <= count + alsch_pkg::CNT_W'(1);
      end else if (kind_q == alsch_pkg::KIND_CLEAR) begin
        count <= '0;
      end
    end else if (cmd.scan_step && match) begin
      // Remove the fired entry: shift from the one after it
      ptr  <= alsch_pkg::CNT_W'(pidx) + alsch_pkg::CNT_W'(1);
      pend <= 1'b0;
    end else if (cmd.scan_step || cmd.shift_step) begin
      if (!at_end) begin
        pidx <= ptr[alsch_pkg::ADDR_W-1:0];
        ptr  <= ptr + alsch_pkg::CNT_W'(1);
        pend <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
      if (cmd.shift_step && !pend && at_end) begin
        count <= count - alsch_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dispatch) begin
      r_acc    <= ((kind_q == alsch_pkg::KIND_ADD) && add_ok) ||
                  ((kind_q == alsch_pkg::KIND_DELETE) && del_ok);
      r_fired  <= 1'b0;
      r_fmel   <= 1'b0;
      r_nvalid <= (kind_q == alsch_pkg::KIND_QUERY) && (count != '0);
      r_nidx   <= '0;
      r_best   <= '1;
    end else if (cmd.scan_step && pend) begin
      if (match) begin
        r_fired <= 1'b1;
        r_fmel  <= rd_mel;
      end else if ((kind_q == alsch_pkg::KIND_QUERY) && (fwd_dist < r_best)) begin
        // Strict compare keeps the lowest index on ties
        r_best <= fwd_dist;
        r_nidx <= alsch_pkg::IDX_W'(pidx);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      accepted      <= r_acc;
      fired         <= r_fired;
      fired_melody  <= r_fmel;
      nearest_valid <= r_nvalid;
      nearest_index <= r_nvalid ? r_nidx : '0;
      minutes_until <= r_nvalid ? r_best : '0;
      entry_count   <= count;
    end
  end

endmodule

// ===== rtl/alarm_schedule_table.sv =====
// ----------------------------------------------------------------------------
// alarm_schedule_table: compact list of alarm entries
// Flow: each transferred item is latched and dispatched; a tick or query on a
//   nonempty table then scans the entries, a valid delete or a fired tick
//   shifts the later entries down, and the result is then registered for output.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset: synchronous, active high; empties the table, no clearing pass.
// ----------------------------------------------------------------------------
module alarm_schedule_table (
  input  logic         clk,
  input  logic         rst,
  alsch_in_if.sink     item_in,
  alsch_out_if.source  result_out
);

  alsch_pkg::cmd_t  cmd;
  alsch_pkg::stat_t stat;

  alsch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .out_valid(result_out.valid),
    .out_ready(result_out.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  alsch_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .kind          (item_in.kind),
    .alarm_minute  (item_in.alarm_minute),
    .melody        (item_in.melody),
    .entry_index   (item_in.entry_index),
    .current_minute(item_in.current_minute),
    .accepted      (result_out.accepted),
    .fired         (result_out.fired),
    .fired_melody  (result_out.fired_melody),
    .nearest_valid (result_out.nearest_valid),
    .nearest_index (result_out.nearest_index),
    .minutes_until (result_out.minutes_until),
    .entry_count   (result_out.entry_count)
  );

endmodule
